/* rtl/tac_pkg.sv */
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants
// Fixed-point widths, Steinhart-Hart coefficients and the sideband record
// that travels with each beat through the conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tac_pkg;

    localparam int PAD_W  = 20;   // divider resistor register
    localparam int RES_W  = 30;   // thermistor resistance in ohms
    localparam int TEMP_W = 16;   // centi-degree result
    localparam int L_W    = 29;   // ln(R) in Q5.24
    localparam int L2_W   = 33;   // ln(R)^2 in Q9.24
    localparam int L3_W   = 38;   // ln(R)^3 in Q14.24
    localparam int D_W    = 40;   // Steinhart-Hart sum in Q0.46
    localparam int NUM_W  = 54;   // reciprocal dividend
    localparam int CK_W   = 17;   // centi-kelvin quotient
    localparam int FRAC_N = 24;   // log2 fraction bits

    localparam logic [PAD_W-1:0]  PAD_RESET = 20'd9850;
    localparam logic [RES_W-1:0]  RES_MAX   = 30'h3FFF_FFFF;
    localparam logic [31:0]       LN2_Q32   = 32'd2977044472;

    // Coefficients in Q0.46, rounded to nearest.
    localparam logic [36:0] COEF_A =
        37'((64'd1129148 * (64'd1 << 37) + 64'd976562) / 64'd1953125);
    localparam logic [33:0] COEF_B =
        34'((64'd234125 * (64'd1 << 37) + 64'd976562) / 64'd1953125);
    localparam logic [22:0] COEF_C =
        23'((64'd876741 * (64'd1 << 33) + 64'd610351562) / 64'd1220703125);

    localparam logic [NUM_W-1:0] RECIP_NUM    = NUM_W'(100) << 46;
    localparam logic [CK_W-1:0]  KELVIN_CENTI = 17'd27315;
    localparam logic [CK_W-1:0]  CK_SAT       = 17'd60082;  // 27315 + 32767
    localparam logic [TEMP_W-1:0] TEMP_MAX    = 16'h7FFF;
    localparam logic [TEMP_W-1:0] TEMP_ABS0   = 16'h954D;   // -27315

    // Register word index on the APB port
    localparam logic REG_PAD = 1'b0;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic             err;   // zero code
        logic             zero;  // zero resistance
    } t_side;

endpackage
`default_nettype wire

/* rtl/tac_if.sv */
// ----------------------------------------------------------------------------
// tac_in_if / tac_out_if: valid-ready channels
// Input channel carries one converter code, output channel one result.
// ----------------------------------------------------------------------------
`default_nettype none
interface tac_in_if #(parameter int ADC_BITS = 10);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_code;
    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface tac_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] temp_centi_c;
    logic [29:0] resistance_ohms;
    logic        div_error;
    modport source (output valid, output temp_centi_c, output resistance_ohms,
                    output div_error, input ready);
    modport sink   (input valid, input temp_centi_c, input resistance_ohms,
                    input div_error, output ready);
endinterface
`default_nettype wire

/* rtl/tac_rdiv.sv */
// ----------------------------------------------------------------------------
// tac_rdiv: resistance divider pipeline
// Restoring long division of pad*2^ADC_BITS by the code, one quotient bit
// per stage, then subtract pad and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module tac_rdiv #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [ADC_BITS-1:0]       i_code,
    input  wire logic [tac_pkg::PAD_W-1:0] i_pad,
    output      logic                      o_valid,
    output      tac_pkg::t_side            o_sd
);
    localparam int QW = tac_pkg::PAD_W + ADC_BITS;
    localparam int NS = QW;

    logic [NS:0]              s_v;
    logic [ADC_BITS-1:0]      s_rem  [NS+1];
    logic [QW-1:0]            s_q    [NS+1];
    logic [QW-1:0]            s_n    [NS+1];
    logic [ADC_BITS-1:0]      s_code [NS+1];
    logic [tac_pkg::PAD_W-1:0] s_pad [NS+1];
    logic [NS:0]              s_err;

    assign s_v[0]    = i_valid;
    assign s_rem[0]  = '0;
    assign s_q[0]    = '0;
    assign s_n[0]    = {i_pad, {ADC_BITS{1'b0}}};
    assign s_code[0] = i_code;
    assign s_pad[0]  = i_pad;
    assign s_err[0]  = (i_code == '0);

    for (genvar i = 0; i < NS; i++) begin : g_st
        logic                      r_v;
        logic [ADC_BITS-1:0]       r_rem;
        logic [QW-1:0]             r_q;
        logic [QW-1:0]             r_n;
        logic [ADC_BITS-1:0]       r_code;
        logic [tac_pkg::PAD_W-1:0] r_pad;
        logic                      r_err;
        logic [ADC_BITS:0]         trial;
        logic                      ge;

        assign trial = {s_rem[i], s_n[i][QW-1]};
        assign ge    = (trial >= {1'b0, s_code[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? ADC_BITS'(trial - {1'b0, s_code[i]})
                             : trial[ADC_BITS-1:0];
                r_q    <= {s_q[i][QW-2:0], ge};
                r_n    <= {s_n[i][QW-2:0], 1'b0};
                r_code <= s_code[i];
                r_pad  <= s_pad[i];
                r_err  <= s_err[i];
            end
        end

        assign s_v[i+1]    = r_v;
        assign s_rem[i+1]  = r_rem;
        assign s_q[i+1]    = r_q;
        assign s_n[i+1]    = r_n;
        assign s_code[i+1] = r_code;
        assign s_pad[i+1]  = r_pad;
        assign s_err[i+1]  = r_err;
    end

    // Subtract pad and clamp to the resistance range
    logic [QW-1:0]             diff;
    logic [tac_pkg::RES_W-1:0] n_res;
    logic                      r_out_v;
    tac_pkg::t_side            r_out_sd;

    assign diff  = s_q[NS] - QW'(s_pad[NS]);
    assign n_res = (diff > QW'(tac_pkg::RES_MAX)) ? tac_pkg::RES_MAX
                                                  : tac_pkg::RES_W'(diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= s_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_sd.res  <= n_res;
            r_out_sd.err  <= s_err[NS];
            r_out_sd.zero <= (n_res == '0);
        end
    end

    assign o_valid = r_out_v;
    assign o_sd    = r_out_sd;
endmodule
`default_nettype wire

/* rtl/tac_ln.sv */
// ----------------------------------------------------------------------------
// tac_ln: natural log pipeline
// Normalize to Q1.30, one squaring per stage for 24 fraction bits of
// log2, then scale by ln2 into Q5.24.
// ----------------------------------------------------------------------------
`default_nettype none
module tac_ln (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire tac_pkg::t_side          i_sd,
    output      logic                    o_valid,
    output      logic [tac_pkg::L_W-1:0] o_l,
    output      tac_pkg::t_side          o_sd
);
    localparam int NS = tac_pkg::FRAC_N;

    // Normalize stage: find the leading one
    logic [4:0]  msb;
    logic        r_nv;
    logic [4:0]  r_ne;
    logic [30:0] r_nx;
    tac_pkg::t_side r_nsd;

    always_comb begin
        msb = '0;
        for (int b = 0; b < tac_pkg::RES_W; b++) begin
            if (i_sd.res[b]) begin
                msb = 5'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (i_en) begin
            r_nv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ne  <= msb;
            r_nx  <= 31'({1'b0, i_sd.res} << (5'd30 - msb));
            r_nsd <= i_sd;
        end
    end

    logic [NS:0]        s_v;
    logic [30:0]        s_x    [NS+1];
    logic [NS-1:0]      s_frac [NS+1];
    logic [4:0]         s_e    [NS+1];
    tac_pkg::t_side     s_sd   [NS+1];

    assign s_v[0]    = r_nv;
    assign s_x[0]    = r_nx;
    assign s_frac[0] = '0;
    assign s_e[0]    = r_ne;
    assign s_sd[0]   = r_nsd;

    for (genvar i = 0; i < NS; i++) begin : g_sq
        logic           r_v;
        logic [30:0]    r_x;
        logic [NS-1:0]  r_frac;
        logic [4:0]     r_e;
        tac_pkg::t_side r_sd;
        logic [61:0]    sq;

        assign sq = s_x[i] * s_x[i];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= sq[61] ? sq[61:31] : sq[60:30];
                r_frac <= {s_frac[i][NS-2:0], sq[61]};
                r_e    <= s_e[i];
                r_sd   <= s_sd[i];
            end
        end

        assign s_v[i+1]    = r_v;
        assign s_x[i+1]    = r_x;
        assign s_frac[i+1] = r_frac;
        assign s_e[i+1]    = r_e;
        assign s_sd[i+1]   = r_sd;
    end

    // Scale log2 by ln2, round to nearest
    logic [28:0]         lg;
    logic [61:0]         prod;
    logic                r_ov;
    logic [tac_pkg::L_W-1:0] r_l;
    tac_pkg::t_side      r_osd;

    assign lg   = {s_e[NS], s_frac[NS]};
    assign prod = 62'(lg) * 62'(tac_pkg::LN2_Q32) + (62'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= s_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l   <= prod[60:32];
            r_osd <= s_sd[NS];
        end
    end

    assign o_valid = r_ov;
    assign o_l     = r_l;
    assign o_sd    = r_osd;
endmodule
`default_nettype wire

/* rtl/tac_shh.sv */
// ----------------------------------------------------------------------------
// tac_shh: Steinhart-Hart polynomial and reciprocal pipeline
// Five stages form D = A + B*L + C*L^3, seventeen stages divide 100*2^46
// by D one quotient bit each, and a final step converts to Celsius.
// ----------------------------------------------------------------------------
`default_nettype none
module tac_shh (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [tac_pkg::L_W-1:0]    i_l,
    input  wire tac_pkg::t_side             i_sd,
    output      logic                       o_valid,
    output      logic [tac_pkg::TEMP_W-1:0] o_temp,
    output      tac_pkg::t_side             o_sd
);
    localparam int NQ = tac_pkg::CK_W;

    logic [4:0]                  r_v;
    tac_pkg::t_side              r_sd [5];
    logic [tac_pkg::L_W-1:0]     r_a_l;
    logic [tac_pkg::L2_W-1:0]    r_a_l2;
    logic [tac_pkg::L3_W-1:0]    r_b_l3;
    logic [38:0]                 r_b_bl, r_c_bl;
    logic [37:0]                 r_c_cl3;
    logic [tac_pkg::D_W-1:0]     r_d_d, r_e_d;
    logic [tac_pkg::NUM_W-1:0]   r_e_num;

    logic [57:0] p_l2;
    logic [61:0] p_l3;
    logic [63:0] p_bl;
    logic [61:0] p_cl3;

    assign p_l2  = 58'(i_l) * 58'(i_l);
    assign p_l3  = 62'(r_a_l2) * 62'(r_a_l);
    assign p_bl  = 64'(tac_pkg::COEF_B) * 64'(r_a_l) + (64'd1 << 23);
    assign p_cl3 = 62'(tac_pkg::COEF_C) * 62'(r_b_l3) + (62'd1 << 23);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_sd;
            for (int k = 1; k < 5; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_a_l   <= i_l;
            r_a_l2  <= p_l2[56:24];
            r_b_l3  <= p_l3[61:24];
            r_b_bl  <= p_bl[62:24];
            r_c_bl  <= r_b_bl;
            r_c_cl3 <= p_cl3[61:24];
            r_d_d   <= tac_pkg::D_W'(tac_pkg::COEF_A) + tac_pkg::D_W'(r_c_bl)
                     + tac_pkg::D_W'(r_c_cl3);
            r_e_d   <= r_d_d;
            r_e_num <= tac_pkg::RECIP_NUM + tac_pkg::NUM_W'(r_d_d >> 1);
        end
    end

    // Reciprocal: one quotient bit per stage, most significant first
    logic [NQ:0]                 s_v;
    logic [tac_pkg::NUM_W-1:0]   s_rem [NQ+1];
    logic [tac_pkg::D_W-1:0]     s_d   [NQ+1];
    logic [NQ-1:0]               s_q   [NQ+1];
    tac_pkg::t_side              s_sd  [NQ+1];

    assign s_v[0]   = r_v[4];
    assign s_rem[0] = r_e_num;
    assign s_d[0]   = r_e_d;
    assign s_q[0]   = '0;
    assign s_sd[0]  = r_sd[4];

    for (genvar j = 0; j < NQ; j++) begin : g_rc
        localparam int K  = NQ - 1 - j;
        localparam int SW = tac_pkg::D_W + NQ;
        logic                      r_qv;
        logic [tac_pkg::NUM_W-1:0] r_rem;
        logic [tac_pkg::D_W-1:0]   r_d;
        logic [NQ-1:0]             r_q;
        tac_pkg::t_side            r_qsd;
        logic [SW-1:0]             dsh;
        logic                      ge;

        assign dsh = SW'(s_d[j]) << K;
        assign ge  = (SW'(s_rem[j]) >= dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv <= 1'b0;
            end else if (i_en) begin
                r_qv <= s_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? tac_pkg::NUM_W'(SW'(s_rem[j]) - dsh) : s_rem[j];
                r_d   <= s_d[j];
                r_q   <= {s_q[j][NQ-2:0], ge};
                r_qsd <= s_sd[j];
            end
        end

        assign s_v[j+1]   = r_qv;
        assign s_rem[j+1] = r_rem;
        assign s_d[j+1]   = r_d;
        assign s_q[j+1]   = r_q;
        assign s_sd[j+1]  = r_qsd;
    end

    // Kelvin to Celsius with saturation at the hot end; an error beat gives 0, zero resistance gives -273.15 degC
    logic [NQ-1:0] ck_off;
    assign ck_off = s_q[NQ] - tac_pkg::KELVIN_CENTI;

    always_comb begin
        if (s_sd[NQ].err) begin
            o_temp = '0;
        end else if (s_sd[NQ].zero) begin
            o_temp = tac_pkg::TEMP_ABS0;
        end else if (s_q[NQ] >= tac_pkg::CK_SAT) begin
            o_temp = tac_pkg::TEMP_MAX;
        end else begin
            o_temp = ck_off[tac_pkg::TEMP_W-1:0];
        end
    end

    assign o_valid = s_v[NQ];
    assign o_sd    = s_sd[NQ];
endmodule
`default_nettype wire

/* rtl/thermistor_adc_to_celsius.sv */
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius: thermistor code to Celsius converter
// Steinhart-Hart conversion of a divider ADC code to hundredths of a degree.
// ----------------------------------------------------------------------------
// Each beat on i_in carries one ADC code from a thermistor divider; the
// matching beat on o_out gives the thermistor resistance in whole ohms,
// the temperature in signed hundredths of a degree Celsius (saturated at
// 327.67 degC) and div_error, set for a zero code with both other fields
// zero. The block is a fixed pipeline that takes one code every cycle
// unless o_out stalls; the resistance long division costs one stage per
// quotient bit (20 + ADC_BITS plus a subtract stage), the log 26 stages
// (normalize, 24 squarings, ln2 scaling), the polynomial five, the
// reciprocal division seventeen, plus the output register. A stall on
// o_out freezes the whole pipeline; i_in.ready follows the output
// register. The divider resistor is set through APB register 0
// (pad_ohms, resets to 9850) and is only to be written while no
// conversion is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module thermistor_adc_to_celsius #(
    parameter int ADC_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tac_in_if.sink           i_in,
    tac_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    // Register file: a single divider resistor value
    logic [tac_pkg::PAD_W-1:0] r_pad;
    logic                      pad_sel;

    assign pad_sel = (paddr[2] == tac_pkg::REG_PAD);
    assign pready  = 1'b1;
    assign prdata  = pad_sel ? 32'(r_pad) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= tac_pkg::PAD_RESET;
        end else if (psel && penable && pwrite && pad_sel) begin
            r_pad <= pwdata[tac_pkg::PAD_W-1:0];
        end
    end

    // Advance every stage together unless a finished beat is held
    logic r_out_v;
    logic en;
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    logic           div_v, ln_v, shh_v;
    tac_pkg::t_side div_sd, ln_sd, shh_sd;
    logic [tac_pkg::L_W-1:0]    ln_l;
    logic [tac_pkg::TEMP_W-1:0] shh_temp;

    tac_rdiv #(.ADC_BITS(ADC_BITS)) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_code  (i_in.adc_code),
        .i_pad   (r_pad),
        .o_valid (div_v),
        .o_sd    (div_sd)
    );

    tac_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_sd    (div_sd),
        .o_valid (ln_v),
        .o_l     (ln_l),
        .o_sd    (ln_sd)
    );

    tac_shh u_shh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ln_v),
        .i_l     (ln_l),
        .i_sd    (ln_sd),
        .o_valid (shh_v),
        .o_temp  (shh_temp),
        .o_sd    (shh_sd)
    );

    // Output register: hold the beat until the sink takes it
    logic [tac_pkg::TEMP_W-1:0] r_temp;
    logic [tac_pkg::RES_W-1:0]  r_res;
    logic                       r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= shh_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp <= shh_temp;
            r_res  <= shh_sd.err ? '0 : shh_sd.res;
            r_err  <= shh_sd.err;
        end
    end

    assign o_out.valid           = r_out_v;
    assign o_out.temp_centi_c    = r_temp;
    assign o_out.resistance_ohms = r_res;
    assign o_out.div_error       = r_err;
endmodule
`default_nettype wire

/* rtl/tac_chk.sv */
// ----------------------------------------------------------------------------
// tac_chk: port checker for the thermistor converter
// Watches the channel ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`default_nettype none
module tac_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_temp,
    input wire logic [29:0] out_res,
    input wire logic        out_err
);
    // Held result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_temp)
            && $stable(out_res) && $stable(out_err))
        else $error("output beat changed while stalled");

    // Input side stalls exactly when a result is held
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    // A zero code gives zero fields
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_err |-> out_temp == '0 && out_res == '0)
        else $error("error beat carries nonzero fields");

    // Never below absolute zero
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> $signed(out_temp) >= -16'sd27315)
        else $error("temperature below absolute zero");
endmodule

bind thermistor_adc_to_celsius tac_chk u_tac_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_temp  (o_out.temp_centi_c),
    .out_res   (o_out.resistance_ohms),
    .out_err   (o_out.div_error)
);
`default_nettype wire
